// ===== design/sfh_pkg.sv =====
// Shared types, queue sizing and hash mixing functions for the seeded hash unit.
`default_nettype none
package sfh_pkg;

    // Work queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One unit of work for the back end.
    // grp: data holds a full 4-byte group {b3,b2,b1,b0}.
    // fin: close the message; without grp, data[23:0] holds cnt left-over bytes.
    typedef struct packed {
        logic        grp;
        logic        fin;
        logic [1:0]  cnt;
        logic [31:0] data;
    } t_op;

    // One round over a full group: two 16-bit little-endian halves
    function automatic logic [31:0] mix_group(input logic [31:0] h_in,
                                              input logic [31:0] grp_bytes);
        logic [31:0] h;
        logic [31:0] hi;
        h  = h_in + {16'h0000, grp_bytes[15:0]};
        hi = {16'h0000, grp_bytes[31:16]};
        h  = (h << 16) ^ ((hi << 11) ^ h);
        h  = h + (h >> 11);
        return h;
    endfunction

    // Tail mix for 0 to 3 left-over bytes
    function automatic logic [31:0] tail_mix(input logic [31:0] h_in,
                                             input logic [23:0] held,
                                             input logic [1:0]  cnt);
        logic [31:0] h;
        h = h_in;
        unique case (cnt)
            2'd3: begin
                h = h + {16'h0000, held[15:0]};
                h = h ^ (h << 16);
                h = h ^ ({24'h000000, held[23:16]} << 18);
                h = h + (h >> 11);
            end
            2'd2: begin
                h = h + {16'h0000, held[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1: begin
                h = h + {24'h000000, held[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // Avalanche, first three steps
    function automatic logic [31:0] aval_first(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    // Avalanche, last three steps
    function automatic logic [31:0] aval_last(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in + (h_in >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== design/sfh_front.sv =====
// Front end: gathers bytes into groups and issues group and finish work to the queue.
`default_nettype none
module sfh_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_has_byte,
    input  wire logic         i_last,
    output logic              o_push,
    output sfh_pkg::t_op      o_op
);
    import sfh_pkg::*;

    logic [23:0] r_held;
    logic [1:0]  r_phase;
    logic [23:0] n_held;
    logic [1:0]  n_phase;
    logic        grp;
    logic [23:0] held_upd;
    logic [1:0]  phase_upd;

    // Byte gathering
    always_comb begin
        grp       = i_has_byte && (r_phase == 2'd3);
        held_upd  = r_held;
        phase_upd = r_phase;
        if (i_has_byte) begin
            unique case (r_phase)
                2'd0: begin
                    held_upd  = {r_held[23:8], i_byte};
                    phase_upd = 2'd1;
                end
                2'd1: begin
                    held_upd  = {r_held[23:16], i_byte, r_held[7:0]};
                    phase_upd = 2'd2;
                end
                2'd2: begin
                    held_upd  = {i_byte, r_held[15:0]};
                    phase_upd = 2'd3;
                end
                default: begin
                    held_upd  = '0;
                    phase_upd = 2'd0;
                end
            endcase
        end
    end

    // Work issue: a full group, a finish, or both (then the tail is empty)
    always_comb begin
        o_push      = i_accept && (grp || i_last);
        o_op.grp    = grp;
        o_op.fin    = i_last;
        o_op.cnt    = grp ? 2'd0 : phase_upd;
        o_op.data   = grp ? {i_byte, r_held} : {8'h00, held_upd};
    end

    // Next state: a seed write or a finished message starts over
    always_comb begin
        n_held  = r_held;
        n_phase = r_phase;
        priority if (i_cfg_we) begin
            n_held  = '0;
            n_phase = 2'd0;
        end else if (i_accept && i_last) begin
            n_held  = '0;
            n_phase = 2'd0;
        end else if (i_accept) begin
            n_held  = held_upd;
            n_phase = phase_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_phase <= 2'd0;
        end else begin
            r_held  <= n_held;
            r_phase <= n_phase;
        end
    end

endmodule
`default_nettype wire

// ===== design/sfh_queue.sv =====
// Small work queue between the front end and the back end.
`default_nettype none
module sfh_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire sfh_pkg::t_op i_op,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_valid,
    output sfh_pkg::t_op      o_op
);
    import sfh_pkg::*;

    t_op            r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue fill level beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("fill level did not track push");

endmodule
`default_nettype wire

// ===== design/sfh_back.sv =====
// Back end: running hash update, tail mix and two-stage avalanche with output register.
`default_nettype none
module sfh_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,
    input  wire logic         i_q_valid,
    input  wire sfh_pkg::t_op i_q_op,
    output logic              o_pop,
    output logic              o_valid,
    output logic [31:0]       o_hash,
    input  wire logic         i_ready
);
    import sfh_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] r_hash;
    logic        r_s1_valid;
    logic [31:0] r_s1_val;
    logic        r_s2_valid;
    logic [31:0] r_s2_val;
    logic        r_o_valid;
    logic [31:0] r_o_hash;

    logic        out_rdy;
    logic        s2_rdy;
    logic        s1_rdy;
    logic [31:0] mixed;
    logic [31:0] fin_val;

    // Stage readiness, back to front
    assign out_rdy = !r_o_valid || i_ready;
    assign s2_rdy  = !r_s2_valid || out_rdy;
    assign s1_rdy  = !r_s1_valid || s2_rdy;

    // Group work never waits; finish work needs room in the avalanche pipe
    assign o_pop   = i_q_valid && (!i_q_op.fin || s1_rdy);

    assign mixed   = mix_group(r_hash, i_q_op.data);
    assign fin_val = i_q_op.grp ? mixed : tail_mix(r_hash, i_q_op.data[23:0], i_q_op.cnt);

    // Seed register and running hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_hash <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
            r_hash <= i_cfg_wdata;
        end else if (o_pop) begin
            if (i_q_op.fin) begin
                r_hash <= r_seed;
            end else begin
                r_hash <= mixed;
            end
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_valid <= o_pop && i_q_op.fin;
            end
            if (s2_rdy) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_rdy) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_op.fin) begin
            r_s1_val <= fin_val;
        end
        if (r_s1_valid && s2_rdy) begin
            r_s2_val <= aval_first(r_s1_val);
        end
        if (r_s2_valid && out_rdy) begin
            r_o_hash <= aval_last(r_s2_val);
        end
    end

    assign o_valid = r_o_valid;
    assign o_hash  = r_o_hash;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_rdy) |=> r_s1_valid)
        else $error("stage 1 result dropped while stalled");

    a_fin_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_op.fin && !i_cfg_we) |=> (r_s1_valid && r_hash == r_seed))
        else $error("finish did not enter the pipe or reload the seed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hash)))
        else $error("output transaction changed while stalled");

endmodule
`default_nettype wire

// ===== design/seeded_superfasthash_unit.sv =====
// Top level of the streaming seeded 32-bit hash unit.
//
// Usage:
//   Slave stream: one message byte per transaction in i_s_tdata; i_s_tuser
//   says whether the byte belongs to the message (0 = bare end marker or idle);
//   i_s_tlast closes the message and asks for its hash.
//   Master stream: one transaction per closed message, the 32-bit hash in
//   o_m_tdata.
//   Config: i_cfg_we with i_cfg_wdata loads the seed and abandons any message
//   in progress; write only while no hash is pending.
// Timing:
//   One transaction per cycle sustained while i_m_tready is high. A closing
//   transaction goes into the work queue, then through the tail mix and the
//   first and second half of the avalanche in registered stages to o_m_tvalid.
//   The per-group mix is combinational on the running hash register.
// Reset: seed is 0, queue and pipeline empty, no partial message.
// Stall: while i_m_tready is low the hash holds in the output register, the
//   stages behind it fill, and the 4-entry queue takes further work until it
//   is full; o_s_tready then drops.
`default_nettype none
module seeded_superfasthash_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Configuration
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,
    // Slave stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  wire logic         i_s_tuser,   // [0] carries_byte
    input  wire logic         i_s_tlast,   // last_item
    // Master stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [31:0]       o_m_tdata    // [31:0] hash_value
);
    import sfh_pkg::*;

    logic accept;
    logic push;
    t_op  push_op;
    logic q_full;
    logic q_valid;
    t_op  q_op;
    logic pop;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    sfh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_accept   (accept),
        .i_byte     (i_s_tdata),
        .i_has_byte (i_s_tuser),
        .i_last     (i_s_tlast),
        .o_push     (push),
        .o_op       (push_op)
    );

    sfh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    sfh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .o_hash      (o_m_tdata),
        .i_ready     (i_m_tready)
    );

endmodule
`default_nettype wire
